// ----- src/rpa_pkg.sv -----
// Shared types and constants of the reference-counted page allocator.
// Used by every module of the block but rpa_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

	localparam int ADDR_W      = 32;
	localparam int COUNT_OUT_W = 8;
	localparam int CFG_INDEX_W = 1;

	localparam int DEFAULT_MAX_PAGES  = 32768;
	localparam int DEFAULT_PAGE_BYTES = 4096;
	localparam int DEFAULT_COUNT_BITS = 8;

	localparam logic [ADDR_W-1:0] DEFAULT_BASE  = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] DEFAULT_LIMIT = 32'h8800_0000;

	typedef enum logic [2:0] {
		REQ_ALLOC   = 3'd0,
		REQ_FREE    = 3'd1,
		REQ_ADD_REF = 3'd2,
		REQ_GET_REF = 3'd3,
		REQ_INIT    = 3'd4
	} req_code_t;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_BAD_ADDR  = 3'd1,
		STATUS_NO_PAGE   = 3'd2,
		STATUS_UNDERFLOW = 3'd3,
		STATUS_SATURATED = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BASE  = 1'b0,
		CFG_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [ADDR_W-1:0] page_address;
	} request_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [ADDR_W-1:0]      result_address;
		logic [COUNT_OUT_W-1:0] ref_count;
		logic                   page_released;
	} result_t;

endpackage

`default_nettype wire

// ----- src/rpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/rpa_geom.sv -----
// Page geometry of the allocator: first page number and page count taken from
// the base and limit registers, and the check of a request address. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_geom import rpa_pkg::*; #(
	parameter int MAX_PAGES  = DEFAULT_MAX_PAGES,
	parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES,
	localparam int IDX_W     = $clog2(MAX_PAGES),
	localparam int DEPTH_W   = $clog2(MAX_PAGES + 1),
	localparam int SHIFT     = $clog2(PAGE_BYTES),
	localparam int PN_W      = ADDR_W + 1 - SHIFT
) (
	input  wire logic                clk,
	input  wire logic [ADDR_W-1:0]   base,
	input  wire logic [ADDR_W-1:0]   limit,
	input  wire logic [ADDR_W-1:0]   page_address,
	output logic      [PN_W-1:0]     first_page_q,
	output logic      [DEPTH_W-1:0]  page_total_q,
	output logic                     addr_ok,
	output logic      [IDX_W-1:0]    addr_idx
);

	localparam int CMP_W = ((PN_W > DEPTH_W) ? PN_W : DEPTH_W) + 1;

	logic [CMP_W-1:0] first_page;
	logic [CMP_W-1:0] limit_page;
	logic [CMP_W-1:0] span;
	logic [DEPTH_W-1:0] page_total;
	logic [CMP_W-1:0] addr_page;
	logic [CMP_W-1:0] offset_pages;
	logic             aligned;

	// Work in page numbers: the first page is the base rounded up, the limit
	// rounded down gives the first page number past the range.
	always_comb begin
		first_page = CMP_W'(base[ADDR_W-1:SHIFT]) + CMP_W'(|base[SHIFT-1:0]);
		limit_page = CMP_W'(limit[ADDR_W-1:SHIFT]);
		span       = limit_page - first_page;
		if (limit_page <= first_page) begin
			page_total = '0;
		end else if (span > CMP_W'(MAX_PAGES)) begin
			page_total = DEPTH_W'(MAX_PAGES);
		end else begin
			page_total = span[DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		first_page_q <= first_page[PN_W-1:0];
		page_total_q <= page_total;
	end

	always_comb begin
		aligned      = (page_address[SHIFT-1:0] == '0);
		addr_page    = CMP_W'(page_address[ADDR_W-1:SHIFT]);
		offset_pages = addr_page - CMP_W'(first_page_q);
		addr_ok      = aligned && (addr_page >= CMP_W'(first_page_q))
			&& (offset_pages < CMP_W'(page_total_q));
		addr_idx     = offset_pages[IDX_W-1:0];
	end

endmodule

`default_nettype wire

// ----- src/refcounted_page_allocator_top.sv -----
// Top level of the reference-counted page allocator: control, count memory
// and free stack. Uses rpa_pkg, rpa_geom and rpa_ram.
//
// Requests come in on start/busy: a request beat is taken at a clock edge with
// start high and busy low. Every request gives exactly one result beat, shown
// on result for one cycle with done high; the receiver cannot stall it.
// Alloc, free, add_ref, get_ref and unknown codes pass a lookup step that
// checks the address and reads the count memory and the free stack, then an
// update step that writes them; the result is on the ports in the cycle after
// the update. busy stays high for one cycle, in the lookup step, so the next
// request can be taken while the previous one is being updated. Init sweeps
// every entry of the count memory, one per cycle, and fills the free stack on
// the way; it holds busy until the sweep ends, and its result follows right after.
// Configuration beats (cfg_valid, always ready) set the base and limit
// addresses; they must be written while no request is in flight, which the
// block itself does not enforce. Reset sets the registers to their defaults
// and empties the stack; the count memory holds no defined value until the first init.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_page_allocator_top import rpa_pkg::*; #(
	parameter int MAX_PAGES  = DEFAULT_MAX_PAGES,
	parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES,
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire request_t               req,
	output logic                        done,
	output result_t                     result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]      cfg_data
);

	localparam int IDX_W   = $clog2(MAX_PAGES);
	localparam int DEPTH_W = $clog2(MAX_PAGES + 1);
	localparam int SHIFT   = $clog2(PAGE_BYTES);
	localparam int PN_W    = ADDR_W + 1 - SHIFT;
	localparam int PAGE_W  = ADDR_W - SHIFT;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration registers.
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= DEFAULT_BASE;
			limit_q <= DEFAULT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control.
	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   in_lookup;
	logic   in_sweep;
	logic   sweep_last;
	logic [IDX_W-1:0] sweep_q;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req.req_type == REQ_INIT) ? ST_SWEEP : ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_d = ST_IDLE;
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != ST_IDLE);
		in_lookup  = (state_q == ST_LOOKUP);
		in_sweep   = (state_q == ST_SWEEP);
		sweep_last = in_sweep && (sweep_q == IDX_W'(MAX_PAGES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_last) begin
				sweep_q <= '0;
			end else if (in_sweep) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
		end
	end

	// Stage 1: request beat held while the address is checked and the
	// memories are read.
	request_t req_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	logic [PN_W-1:0]    first_page_q;
	logic [DEPTH_W-1:0] page_total_q;
	logic               addr_ok;
	logic [IDX_W-1:0]   addr_idx;

	rpa_geom #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_geom (
		.clk          (clk),
		.base         (base_q),
		.limit        (limit_q),
		.page_address (req_s1.page_address),
		.first_page_q (first_page_q),
		.page_total_q (page_total_q),
		.addr_ok      (addr_ok),
		.addr_idx     (addr_idx)
	);

	logic [DEPTH_W-1:0] depth_q;

	logic                  cnt_we;
	logic [IDX_W-1:0]      cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic                  stk_we;
	logic [IDX_W-1:0]      stk_waddr;
	logic [IDX_W-1:0]      stk_wdata;
	logic [IDX_W-1:0]      stk_rdata;
	logic [IDX_W-1:0]      stk_raddr;

	// The top of the stack sits one below the depth; on an empty stack the
	// read is discarded.
	assign stk_raddr = IDX_W'(depth_q - DEPTH_W'(1));

	rpa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (addr_idx),
		.rdata (cnt_rdata)
	);

	rpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Stage 2: read data is back; compute the update and the result.
	logic              valid_s2;
	logic [2:0]        type_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              ok_s2;
	logic [IDX_W-1:0]  idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (in_lookup) begin
			type_s2 <= req_s1.req_type;
			addr_s2 <= req_s1.page_address;
			ok_s2   <= addr_ok;
			idx_s2  <= addr_idx;
		end
	end

	logic [2:0]            upd_status;
	logic [ADDR_W-1:0]     upd_addr;
	logic [COUNT_BITS-1:0] upd_count;
	logic [COUNT_BITS-1:0] out_count;
	logic                  upd_we;
	logic [IDX_W-1:0]      upd_idx;
	logic                  upd_push;
	logic                  upd_pop;
	logic                  upd_released;
	logic [PAGE_W-1:0]     alloc_page;

	assign alloc_page = PAGE_W'(first_page_q) + PAGE_W'(stk_rdata);

	always_comb begin
		upd_status   = STATUS_OK;
		upd_addr     = addr_s2;
		upd_count    = cnt_rdata;
		out_count    = '0;
		upd_we       = 1'b0;
		upd_idx      = idx_s2;
		upd_push     = 1'b0;
		upd_pop      = 1'b0;
		upd_released = 1'b0;
		case (type_s2)
			REQ_ALLOC: begin
				if (depth_q == '0) begin
					upd_status = STATUS_NO_PAGE;
					upd_addr   = '0;
				end else begin
					upd_pop   = 1'b1;
					upd_we    = 1'b1;
					upd_idx   = stk_rdata;
					upd_count = COUNT_BITS'(1);
					out_count = COUNT_BITS'(1);
					upd_addr  = {alloc_page, {SHIFT{1'b0}}};
				end
			end
			REQ_FREE: begin
				if (!ok_s2) begin
					upd_status = STATUS_BAD_ADDR;
				end else if (cnt_rdata == '0) begin
					upd_status = STATUS_UNDERFLOW;
				end else begin
					upd_we    = 1'b1;
					upd_count = cnt_rdata - COUNT_BITS'(1);
					out_count = upd_count;
					if (upd_count == '0) begin
						upd_released = 1'b1;
						// A push onto a full stack is dropped.
						upd_push = (depth_q < DEPTH_W'(MAX_PAGES));
					end
				end
			end
			REQ_ADD_REF: begin
				if (!ok_s2) begin
					upd_status = STATUS_BAD_ADDR;
				end else if (cnt_rdata == COUNT_MAX) begin
					upd_status = STATUS_SATURATED;
				end else begin
					upd_we    = 1'b1;
					upd_count = cnt_rdata + COUNT_BITS'(1);
					out_count = upd_count;
				end
			end
			REQ_GET_REF: begin
				if (!ok_s2) begin
					upd_status = STATUS_BAD_ADDR;
				end else begin
					out_count = cnt_rdata;
				end
			end
			default: upd_status = STATUS_BAD_ADDR;
		endcase
	end

	// Memory write ports: the init sweep owns them while it runs.
	always_comb begin
		if (in_sweep) begin
			cnt_we    = 1'b1;
			cnt_waddr = sweep_q;
			cnt_wdata = '0;
			stk_we    = (DEPTH_W'(sweep_q) < page_total_q);
			stk_waddr = sweep_q;
			stk_wdata = sweep_q;
		end else begin
			cnt_we    = valid_s2 && upd_we;
			cnt_waddr = upd_idx;
			cnt_wdata = upd_count;
			stk_we    = valid_s2 && upd_push;
			stk_waddr = depth_q[IDX_W-1:0];
			stk_wdata = idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (sweep_last) begin
			depth_q <= page_total_q;
		end else if (valid_s2 && upd_pop) begin
			depth_q <= depth_q - DEPTH_W'(1);
		end else if (valid_s2 && upd_push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end
	end

	// Result beat register.
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2 || sweep_last;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_last) begin
			result_q.status         <= STATUS_OK;
			result_q.result_address <= req_s1.page_address;
			result_q.ref_count      <= '0;
			result_q.page_released  <= 1'b0;
		end else if (valid_s2) begin
			result_q.status         <= upd_status;
			result_q.result_address <= upd_addr;
			result_q.ref_count      <= COUNT_OUT_W'(out_count);
			result_q.page_released  <= upd_released;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s2 || sweep_last))
		else $error("result beat without a finished request");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_PAGES))
		else $error("free stack depth beyond its capacity");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !in_sweep)
		else $error("update stage active during the init sweep");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && upd_push) |-> (depth_q < DEPTH_W'(MAX_PAGES)))
		else $error("push onto a full free stack");

	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && type_s2 == REQ_ALLOC && depth_q != '0)
		|=> (depth_q == $past(depth_q) - DEPTH_W'(1)))
		else $error("successful alloc did not pop the free stack");

endmodule

`default_nettype wire

// ----- sim/rpa_checker.sv -----
// Result checker for the reference-counted page allocator: it predicts every
// result from the request and register beats that it sees and compares it with
// the result beats. Depends on rpa_pkg only.
`timescale 1ns / 1ps

module rpa_checker import rpa_pkg::*; #(
	parameter int MAX_PAGES  = DEFAULT_MAX_PAGES,
	parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES,
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  request_t               req,
	input  logic                   done,
	input  result_t                result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,
	output int                     failures,
	output int                     pending,
	output int                     checked,
	output int                     released,
	output int                     empties,
	output int                     saturations
);

	localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 64'd1;

	logic [ADDR_W-1:0] base_reg;
	logic [ADDR_W-1:0] limit_reg;
	int unsigned       free_pages[MAX_PAGES];
	int unsigned       free_depth;
	int unsigned       page_counts[MAX_PAGES];
	result_t           predicted_replies[$];

	function automatic longint unsigned first_page();
		longint unsigned b;
		b = {32'd0, base_reg} + 64'(PAGE_BYTES - 1);
		return (b / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
	endfunction

	function automatic longint unsigned managed_pages();
		longint unsigned f;
		longint unsigned n;
		f = first_page();
		if (f + 64'(PAGE_BYTES) > {32'd0, limit_reg})
			return 0;
		n = ({32'd0, limit_reg} - f) / 64'(PAGE_BYTES);
		return (n > 64'(MAX_PAGES)) ? 64'(MAX_PAGES) : n;
	endfunction

	// True when the address is the start of a page inside the current window.
	function automatic bit page_of(input logic [ADDR_W-1:0] addr, output int unsigned idx);
		longint unsigned f;
		longint unsigned k;
		f = first_page();
		idx = 0;
		if ({32'd0, addr} % 64'(PAGE_BYTES) != 0 || {32'd0, addr} < f)
			return 0;
		k = ({32'd0, addr} - f) / 64'(PAGE_BYTES);
		if (k >= managed_pages())
			return 0;
		idx = int'(k);
		return 1;
	endfunction

	function automatic result_t allocator_step(input request_t r);
		result_t         res;
		int unsigned     idx;
		int unsigned     cnt;
		longint unsigned n;
		res.status = STATUS_OK;
		res.result_address = r.page_address;
		res.page_released = 1'b0;
		cnt = 0;
		case (r.req_type)
			REQ_ALLOC: begin
				if (free_depth == 0) begin
					res.status = STATUS_NO_PAGE;
					res.result_address = '0;
				end else begin
					free_depth = free_depth - 1;
					idx = free_pages[free_depth] % MAX_PAGES;
					page_counts[idx] = 1;
					res.result_address = 32'(first_page() + 64'(idx) * 64'(PAGE_BYTES));
					cnt = 1;
				end
			end
			REQ_FREE: begin
				if (!page_of(r.page_address, idx)) begin
					res.status = STATUS_BAD_ADDR;
				end else if (page_counts[idx] == 0) begin
					res.status = STATUS_UNDERFLOW;
				end else begin
					page_counts[idx] = page_counts[idx] - 1;
					cnt = page_counts[idx];
					if (cnt == 0) begin
						res.page_released = 1'b1;
						// A full stack silently drops the push.
						if (free_depth < MAX_PAGES) begin
							free_pages[free_depth] = idx;
							free_depth = free_depth + 1;
						end
					end
				end
			end
			REQ_ADD_REF: begin
				if (!page_of(r.page_address, idx)) begin
					res.status = STATUS_BAD_ADDR;
				end else if (64'(page_counts[idx]) >= COUNT_CEIL) begin
					res.status = STATUS_SATURATED;
				end else begin
					page_counts[idx] = page_counts[idx] + 1;
					cnt = page_counts[idx];
				end
			end
			REQ_GET_REF: begin
				if (!page_of(r.page_address, idx))
					res.status = STATUS_BAD_ADDR;
				else
					cnt = page_counts[idx];
			end
			REQ_INIT: begin
				n = managed_pages();
				for (int k = 0; k < MAX_PAGES; k++)
					page_counts[k] = 0;
				for (int k = 0; k < int'(n); k++)
					free_pages[k] = k;
				free_depth = int'(n);
			end
			default: begin
				res.status = STATUS_BAD_ADDR;
			end
		endcase
		res.ref_count = cnt[COUNT_OUT_W-1:0];
		return res;
	endfunction

	task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	task automatic match_reply(input result_t got);
		result_t want;
		if (predicted_replies.size() == 0) begin
			failures++;
			$display("%0t: result beat with nothing outstanding, expected none, actual %h",
				$time, got);
			return;
		end
		want = predicted_replies.pop_front();
		checked++;
		if (want.page_released)
			released++;
		if (want.status == STATUS_NO_PAGE)
			empties++;
		if (want.status == STATUS_SATURATED)
			saturations++;
		compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
		compare_field("result_address", want.result_address, got.result_address);
		compare_field("ref_count", ADDR_W'(want.ref_count), ADDR_W'(got.ref_count));
		compare_field("page_released", ADDR_W'(want.page_released),
			ADDR_W'(got.page_released));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = DEFAULT_BASE;
			limit_reg = DEFAULT_LIMIT;
			free_depth = 0;
			predicted_replies.delete();
			failures = 0;
			pending = 0;
			checked = 0;
			released = 0;
			empties = 0;
			saturations = 0;
		end else begin
			// The result beat always belongs to an older request than one taken now.
			if (done)
				match_reply(result);
			if (start && !busy)
				predicted_replies.push_back(allocator_step(req));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BASE:  base_reg = cfg_data;
					CFG_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			pending = predicted_replies.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the reference-counted page allocator: clock, reset,
// request and register stimulus, and the verdict. Depends on rpa_pkg, the
// allocator RTL and rpa_checker.
`timescale 1ns / 1ps

module tb_top;
	import rpa_pkg::*;

	localparam int MAX_PAGES  = DEFAULT_MAX_PAGES;
	localparam int PAGE_BYTES = DEFAULT_PAGE_BYTES;
	localparam int COUNT_BITS = DEFAULT_COUNT_BITS;

	localparam logic [2:0] REQ_BOGUS_FIRST = REQ_INIT + 3'd1;
	localparam logic [2:0] REQ_BOGUS_LAST  = '1;

	localparam int WRITE_BOTH = 0;
	localparam int ONLY_BASE  = 1;
	localparam int ONLY_LIMIT = 2;

	localparam int SHAPE_DEFAULT = 0;
	localparam int SHAPE_TINY    = 1;
	localparam int SHAPE_ONE     = 2;
	localparam int SHAPE_TOP     = 3;
	localparam int SHAPE_WIDE    = 4;
	localparam int SHAPE_EMPTY   = 5;
	localparam int SHAPE_RANDOM  = 6;

	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 95;
	localparam int HOT_ITEMS   = 500;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	request_t               req;
	logic                   done;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]      cfg_data;

	int failures;
	int pending;
	int checked;
	int released;
	int empties;
	int saturations;

	bit                gaps_on;
	int                items_sent;
	int                inits_sent;
	int                settings_used;
	logic [ADDR_W-1:0] win_base;
	logic [ADDR_W-1:0] win_limit;

	refcounted_page_allocator_top #(
		.MAX_PAGES(MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rpa_checker #(
		.MAX_PAGES(MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES),
		.COUNT_BITS(COUNT_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending),
		.checked(checked),
		.released(released),
		.empties(empties),
		.saturations(saturations)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// An init sweeps every count entry, so the bound allows for about seventy of them.
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", pending);
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned page_ceil(input logic [ADDR_W-1:0] a);
		return (({32'd0, a} + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
	endfunction

	function automatic void window(output longint unsigned f, output longint unsigned n);
		f = page_ceil(win_base);
		if (f + 64'(PAGE_BYTES) > {32'd0, win_limit}) begin
			n = 0;
		end else begin
			n = ({32'd0, win_limit} - f) / 64'(PAGE_BYTES);
			if (n > 64'(MAX_PAGES))
				n = 64'(MAX_PAGES);
		end
	endfunction

	// Mostly pages inside the window; in a large window the top pages, since
	// those are handed out first. The rest lands on the edges, inside a page or anywhere.
	function automatic logic [ADDR_W-1:0] pick_page();
		longint unsigned f;
		longint unsigned n;
		longint unsigned k;
		int              roll;
		window(f, n);
		roll = $urandom_range(0, 99);
		if (n == 0 || roll < 8)
			return $urandom;
		if (roll < 12)
			return 32'(f + n * 64'(PAGE_BYTES));
		if (roll < 15)
			return 32'(f - 64'(PAGE_BYTES));
		if (n <= 64)
			k = $urandom_range(0, int'(n) - 1);
		else
			k = n - 1 - $urandom_range(0, 31);
		if (roll < 18)
			return 32'(f + k * 64'(PAGE_BYTES) + $urandom_range(1, PAGE_BYTES - 1));
		return 32'(f + k * 64'(PAGE_BYTES));
	endfunction

	// Entered and left at a falling edge; start stays high for the next beat.
	task automatic send(input logic [2:0] code, input logic [ADDR_W-1:0] addr);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		req <= {code, addr};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (code == REQ_INIT)
			inits_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_window(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] l,
			input int which);
		for (int i = 0; i < 2; i++) begin
			if ((i == 0 && which == ONLY_LIMIT) || (i == 1 && which == ONLY_BASE))
				continue;
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? CFG_BASE : CFG_LIMIT;
			cfg_data <= (i == 0) ? b : l;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		if (which != ONLY_LIMIT)
			win_base = b;
		if (which != ONLY_BASE)
			win_limit = l;
		settings_used++;
	endtask

	task automatic random_request(input bit hot);
		int roll;
		roll = $urandom_range(0, 99);
		if (hot) begin
			if (roll < 85)
				send(REQ_ADD_REF, pick_page());
			else if (roll < 90)
				send(REQ_GET_REF, pick_page());
			else if (roll < 95)
				send(REQ_FREE, pick_page());
			else
				send(REQ_ALLOC, $urandom);
		end else begin
			if (roll < 30)
				send(REQ_ALLOC, $urandom);
			else if (roll < 60)
				send(REQ_FREE, pick_page());
			else if (roll < 77)
				send(REQ_ADD_REF, pick_page());
			else if (roll < 95)
				send(REQ_GET_REF, pick_page());
			else
				send(3'($urandom_range(REQ_BOGUS_FIRST, REQ_BOGUS_LAST)), $urandom);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] l;
		logic [ADDR_W-1:0] top_page;
		longint unsigned   f;
		int                shape;
		int                which;
		int                waited;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		gaps_on = 1'b1;
		items_sent = 0;
		inits_sent = 0;
		settings_used = 0;
		win_base = DEFAULT_BASE;
		win_limit = DEFAULT_LIMIT;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Before the first init only requests that touch no count are legal.
		send(REQ_ALLOC, '0);
		send(REQ_GET_REF, DEFAULT_BASE + 32'd1);
		send(REQ_FREE, DEFAULT_BASE - PAGE_BYTES);
		send(REQ_BOGUS_FIRST, '1);
		send(REQ_BOGUS_LAST, '0);
		send(REQ_INIT, '0);

		// The default window fills the stack, so releasing a page that was never
		// handed out drops the push.
		top_page = DEFAULT_LIMIT - PAGE_BYTES;
		send(REQ_ADD_REF, DEFAULT_BASE);
		send(REQ_FREE, DEFAULT_BASE);
		send(REQ_FREE, DEFAULT_BASE);
		send(REQ_ALLOC, '0);
		send(REQ_ADD_REF, top_page);
		send(REQ_GET_REF, top_page);
		send(REQ_FREE, top_page);
		send(REQ_FREE, top_page);
		send(REQ_ALLOC, '0);
		send(REQ_ADD_REF, DEFAULT_LIMIT);
		send(REQ_GET_REF, top_page + PAGE_BYTES / 2);
		settle();

		// Three pages at address zero, then a window at the very top that holds
		// no page: popped indices turn into addresses that wrap past 2^32.
		program_window('0, 3 * PAGE_BYTES, WRITE_BOTH);
		send(REQ_INIT, $urandom);
		settle();
		program_window(32'hFFFF_F000, 32'hFFFF_FFFF, WRITE_BOTH);
		repeat (4) send(REQ_ALLOC, $urandom);
		send(REQ_GET_REF, 32'hFFFF_F000);
		send(REQ_INIT, '0);
		send(REQ_ALLOC, '0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0, 7, 10: shape = SHAPE_TINY;
				1, 11:    shape = SHAPE_DEFAULT;
				2:        shape = SHAPE_ONE;
				3, 8:     shape = SHAPE_TOP;
				4:        shape = SHAPE_WIDE;
				5:        shape = SHAPE_EMPTY;
				default:  shape = SHAPE_RANDOM;
			endcase
			gaps_on = (p < NUM_PHASES - 2);
			settle();
			which = WRITE_BOTH;
			case (shape)
				SHAPE_TINY: begin
					b = $urandom_range(0, 32'hFFF0_0000);
					f = page_ceil(b);
					l = 32'(f + 64'($urandom_range(1, 16)) * 64'(PAGE_BYTES)
						+ $urandom_range(0, PAGE_BYTES - 1));
				end
				SHAPE_ONE: begin
					b = $urandom_range(0, 32'hFFF0_0000);
					f = page_ceil(b);
					l = 32'(f + 64'(PAGE_BYTES) + $urandom_range(0, PAGE_BYTES - 1));
				end
				SHAPE_TOP: begin
					b = $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
					l = '1;
				end
				SHAPE_WIDE: begin
					b = $urandom_range(0, 1) ? '0 : $urandom_range(0, 32'h00FF_FFFF);
					l = '1;
				end
				SHAPE_EMPTY: begin
					if ($urandom_range(0, 1)) begin
						b = '1;
						l = '0;
					end else begin
						b = $urandom;
						l = $urandom_range(0, b);
					end
				end
				SHAPE_RANDOM: begin
					b = $urandom;
					l = $urandom;
					which = $urandom_range(WRITE_BOTH, ONLY_LIMIT);
				end
				default: begin
					b = DEFAULT_BASE;
					l = DEFAULT_LIMIT;
				end
			endcase
			program_window(b, l, which);
			// Skipping init now and then keeps the old stack under the new window.
			if (shape == SHAPE_ONE || $urandom_range(0, 3) != 0)
				send(REQ_INIT, $urandom);
			repeat (shape == SHAPE_ONE ? HOT_ITEMS : PHASE_ITEMS)
				random_request(shape == SHAPE_ONE);
		end

		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < MAX_PAGES + 64) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);

		$display("Sent %0d requests (%0d inits) over %0d register settings; %0d results checked.",
			items_sent, inits_sent, settings_used, checked);
		$display("Saw %0d page releases, %0d allocs on an empty stack, %0d saturated add_refs.",
			released, empties, saturations);
		if (failures == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			if (pending != 0)
				$display("%0d results never arrived", pending);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
